@@ rtl/core/scp2c_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the scan
// polar-to-cartesian unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scp2c_pkg;

    localparam int TABLE_FRAC_BITS = 18;
    localparam int MAG_W           = TABLE_FRAC_BITS + 1;   // 1.0 = 2^18 needs 19 bits
    localparam int DIST_W          = 16;
    localparam int COORD_W         = 17;
    localparam int PLANE_W         = 16;
    localparam int SPACING_W       = 16;
    localparam int POS_W           = 32;
    localparam int STEP_W          = 8;
    localparam int TANGLE_W        = 8;                      // 256-step table circle

    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd500;

    // Register word index on the APB port
    localparam logic [0:0] REG_PLANE_SPACING = 1'b0;

    typedef logic [TANGLE_W-1:0] table_angle_t;

    // Per-sample scan info handed from the counter block to the datapath
    typedef struct packed {
        table_angle_t         table_angle;
        logic [STEP_W-1:0]    angle_step;
        logic                 last;
        logic [PLANE_W-1:0]   plane_count;
    } scan_info_t;

    // round(sin(k * 90/64 deg) * 2^18), k = 0..64
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [6:0] k);
        logic [MAG_W-1:0] v;
        case (k)
            7'd0:  v = 19'd0;      7'd1:  v = 19'd6433;   7'd2:  v = 19'd12863;
            7'd3:  v = 19'd19285;  7'd4:  v = 19'd25695;  7'd5:  v = 19'd32089;
            7'd6:  v = 19'd38465;  7'd7:  v = 19'd44817;  7'd8:  v = 19'd51142;
            7'd9:  v = 19'd57436;  7'd10: v = 19'd63696;  7'd11: v = 19'd69917;
            7'd12: v = 19'd76096;  7'd13: v = 19'd82230;  7'd14: v = 19'd88314;
            7'd15: v = 19'd94344;  7'd16: v = 19'd100318; 7'd17: v = 19'd106232;
            7'd18: v = 19'd112081; 7'd19: v = 19'd117863; 7'd20: v = 19'd123574;
            7'd21: v = 19'd129210; 7'd22: v = 19'd134769; 7'd23: v = 19'd140246;
            7'd24: v = 19'd145639; 7'd25: v = 19'd150945; 7'd26: v = 19'd156159;
            7'd27: v = 19'd161279; 7'd28: v = 19'd166302; 7'd29: v = 19'd171225;
            7'd30: v = 19'd176045; 7'd31: v = 19'd180759; 7'd32: v = 19'd185364;
            7'd33: v = 19'd189857; 7'd34: v = 19'd194236; 7'd35: v = 19'd198498;
            7'd36: v = 19'd202640; 7'd37: v = 19'd206660; 7'd38: v = 19'd210556;
            7'd39: v = 19'd214325; 7'd40: v = 19'd217965; 7'd41: v = 19'd221473;
            7'd42: v = 19'd224848; 7'd43: v = 19'd228088; 7'd44: v = 19'd231190;
            7'd45: v = 19'd234153; 7'd46: v = 19'd236975; 7'd47: v = 19'd239655;
            7'd48: v = 19'd242189; 7'd49: v = 19'd244578; 7'd50: v = 19'd246820;
            7'd51: v = 19'd248913; 7'd52: v = 19'd250856; 7'd53: v = 19'd252648;
            7'd54: v = 19'd254288; 7'd55: v = 19'd255774; 7'd56: v = 19'd257107;
            7'd57: v = 19'd258285; 7'd58: v = 19'd259307; 7'd59: v = 19'd260173;
            7'd60: v = 19'd260882; 7'd61: v = 19'd261434; 7'd62: v = 19'd261828;
            7'd63: v = 19'd262065; 7'd64: v = 19'd262144;
            default: v = 19'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/scp2c_scan_state.sv @@
// Scan counters: angle index, sample count and plane count, plus the
// mapping of the angle index onto the 256-step table circle. Uses scp2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scp2c_scan_state #(
    parameter int STEPS_PER_TURN = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    output scp2c_pkg::scan_info_t  info
);

    localparam int IDX_W  = $clog2(STEPS_PER_TURN);
    localparam int EXT_W  = (IDX_W > scp2c_pkg::STEP_W) ? IDX_W : scp2c_pkg::STEP_W;
    // index * 256 / STEPS_PER_TURN by reciprocal multiply, exact for x < 2^X_W
    localparam int X_W    = IDX_W + scp2c_pkg::TANGLE_W;
    localparam int SH     = X_W + IDX_W;
    localparam longint RECIP_L = ((64'd1 << SH) + STEPS_PER_TURN - 1) / STEPS_PER_TURN;
    localparam logic [X_W:0] RECIP = (X_W + 1)'(RECIP_L);
    localparam logic [IDX_W-1:0] ANGLE_RESET = IDX_W'(STEPS_PER_TURN / 4);
    localparam logic [IDX_W-1:0] IDX_MAX     = IDX_W'(STEPS_PER_TURN - 1);

    logic [IDX_W-1:0]              angle_index_reg, angle_index_next;
    logic [IDX_W-1:0]              sample_count_reg, sample_count_next;
    logic [scp2c_pkg::PLANE_W-1:0] plane_count_reg, plane_count_next;
    logic                          last;
    logic [X_W-1:0]                scaled;
    logic [2*X_W:0]                prod;
    logic [EXT_W-1:0]              step_ext;

    assign last     = (sample_count_reg == IDX_MAX);
    assign scaled   = {angle_index_reg, {scp2c_pkg::TANGLE_W{1'b0}}};
    assign prod     = (2*X_W+1)'(scaled) * (2*X_W+1)'(RECIP);
    assign step_ext = EXT_W'(angle_index_reg);

    always_comb begin
        angle_index_next  = (angle_index_reg == '0) ? IDX_MAX : angle_index_reg - 1'b1;
        sample_count_next = last ? '0 : sample_count_reg + 1'b1;
        plane_count_next  = plane_count_reg;
        if (last && (plane_count_reg != {scp2c_pkg::PLANE_W{1'b1}})) begin
            plane_count_next = plane_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_index_reg  <= ANGLE_RESET;
            sample_count_reg <= '0;
            plane_count_reg  <= '0;
        end else if (advance) begin
            angle_index_reg  <= angle_index_next;
            sample_count_reg <= sample_count_next;
            plane_count_reg  <= plane_count_next;
        end
    end

    assign info.table_angle = prod[SH +: scp2c_pkg::TANGLE_W];
    assign info.angle_step  = step_ext[scp2c_pkg::STEP_W-1:0];
    assign info.last        = last;
    assign info.plane_count = plane_count_reg;

endmodule

`default_nettype wire

@@ rtl/core/scp2c_axis_mult.sv @@
// One coordinate axis: quadrant fold, sine table lookup, distance multiply,
// truncation toward zero and sign. Uses scp2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scp2c_axis_mult (
    input  wire logic [scp2c_pkg::DIST_W-1:0]   distance,
    input  wire scp2c_pkg::table_angle_t        angle,
    output logic signed [scp2c_pkg::COORD_W-1:0] coord
);

    localparam int PROD_W = scp2c_pkg::DIST_W + scp2c_pkg::MAG_W;

    logic [6:0]                       k;
    logic [scp2c_pkg::MAG_W-1:0]      mag;
    logic [PROD_W-1:0]                prod;
    logic [scp2c_pkg::COORD_W-1:0]    m;

    // odd quadrants read the table mirrored, upper half circle is negative
    assign k     = angle[6] ? (7'd64 - {1'b0, angle[5:0]}) : {1'b0, angle[5:0]};
    assign mag   = scp2c_pkg::quarter_sine(k);
    assign prod  = PROD_W'(distance) * PROD_W'(mag);
    assign m     = prod[scp2c_pkg::TABLE_FRAC_BITS +: scp2c_pkg::COORD_W];
    assign coord = angle[7] ? -$signed(m) : $signed(m);

endmodule

`default_nettype wire

@@ rtl/core/scan_polar_to_cartesian_unit.sv @@
// Top level of the scan polar-to-cartesian unit: APB register, input and
// result stages. Uses scp2c_pkg, scp2c_scan_state and scp2c_axis_mult.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel s_*: one range sample (s_distance, mm) per beat.
//   Result channel m_*: one point per sample: x = plane position
//   (plane count * spacing), y = d*cos, z = d*sin, both truncated toward
//   zero, the angle index used, and a flag on the last sample of a turn.
//   The angle starts at a quarter turn and drops one step per sample.
//   APB: word 0 is plane_spacing (reset 500); write only while idle.
// Timing
//   Two register stages: the input stage captures the sample with the scan
//   counters' snapshot, the result stage holds the table lookups and the
//   three multiplies. A taken beat goes to the input stage, then to the
//   result stage on m_*. One beat per cycle while m_ready holds; both stages
//   advance together whenever the result stage is empty or being drained.
// Reset and stall
//   Reset empties both stages, sets the angle to a quarter turn and clears
//   the sample and plane counts. If m_ready is held low, results stay put;
//   the input stage absorbs one more beat, then s_ready drops.
module scan_polar_to_cartesian_unit #(
    parameter int STEPS_PER_TURN = 256
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // APB register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready,
    // sample input
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [scp2c_pkg::DIST_W-1:0]         s_distance,
    // point output
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [scp2c_pkg::POS_W-1:0]               m_plane_position,
    output logic signed [scp2c_pkg::COORD_W-1:0]      m_y_coord,
    output logic signed [scp2c_pkg::COORD_W-1:0]      m_z_coord,
    output logic [scp2c_pkg::STEP_W-1:0]              m_angle_step,
    output logic                                      m_last_in_plane
);

    // ---------------- register port ----------------
    logic [scp2c_pkg::SPACING_W-1:0] spacing_reg;
    logic                            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == scp2c_pkg::REG_PLANE_SPACING);
    assign prdata    = (paddr[2] == scp2c_pkg::REG_PLANE_SPACING) ?
                       {{(32-scp2c_pkg::SPACING_W){1'b0}}, spacing_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= scp2c_pkg::SPACING_RESET;
        end else if (cfg_write) begin
            spacing_reg <= pwdata[scp2c_pkg::SPACING_W-1:0];
        end
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_load;     // result stage takes the input stage this cycle
    logic in_load;      // input beat accepted

    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // ---------------- scan counters ----------------
    scp2c_pkg::scan_info_t cur_info;

    scp2c_scan_state #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_scan_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (in_load),
        .info    (cur_info)
    );

    // ---------------- input stage ----------------
    logic [scp2c_pkg::DIST_W-1:0] s1_distance_reg;
    scp2c_pkg::scan_info_t        s1_info_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            s1_distance_reg <= s_distance;
            s1_info_reg     <= cur_info;
        end
    end

    // ---------------- result datapath ----------------
    scp2c_pkg::table_angle_t                cos_angle;
    logic signed [scp2c_pkg::COORD_W-1:0]   y_next;
    logic signed [scp2c_pkg::COORD_W-1:0]   z_next;
    logic [scp2c_pkg::POS_W-1:0]            position_next;

    // cos(a) = sin(a + quarter turn)
    assign cos_angle = s1_info_reg.table_angle + 8'd64;

    scp2c_axis_mult u_axis_y (
        .distance (s1_distance_reg),
        .angle    (cos_angle),
        .coord    (y_next)
    );

    scp2c_axis_mult u_axis_z (
        .distance (s1_distance_reg),
        .angle    (s1_info_reg.table_angle),
        .coord    (z_next)
    );

    assign position_next = scp2c_pkg::POS_W'(s1_info_reg.plane_count) *
                           scp2c_pkg::POS_W'(spacing_reg);

    // ---------------- result stage ----------------
    logic [scp2c_pkg::POS_W-1:0]            position_reg;
    logic signed [scp2c_pkg::COORD_W-1:0]   y_reg;
    logic signed [scp2c_pkg::COORD_W-1:0]   z_reg;
    logic [scp2c_pkg::STEP_W-1:0]           step_reg;
    logic                                   last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && s1_valid_reg) begin
            position_reg <= position_next;
            y_reg        <= y_next;
            z_reg        <= z_next;
            step_reg     <= s1_info_reg.angle_step;
            last_reg     <= s1_info_reg.last;
        end
    end

    assign m_plane_position = position_reg;
    assign m_y_coord        = y_reg;
    assign m_z_coord        = z_reg;
    assign m_angle_step     = step_reg;
    assign m_last_in_plane  = last_reg;

    // ---------------- assertions ----------------
    // a stalled result with a full input stage must block new beats
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && s1_valid_reg) |-> !s_ready)
        else $error("input accepted while both stages are full and stalled");

    // an item in the input stage reaches the result stage when it loads
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_load) |=> m_valid_reg)
        else $error("item lost between input and result stage");

    // plane count never goes backward
    a_plane_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (cur_info.plane_count >= $past(cur_info.plane_count)))
        else $error("plane count decreased");

endmodule

`default_nettype wire
